[rtl/ssrl_pkg.sv]
`default_nettype none

package ssrl_pkg;

  localparam int MAX_SYMBOLS = 512;
  localparam int IDX_W       = $clog2(MAX_SYMBOLS);
  localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);
  localparam int TOTAL_W     = 10;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;
  localparam logic [1:0] REQ_NOP    = 2'd3;

  localparam logic [3:0]  FUNC_TYPE      = 4'h2;
  localparam logic [31:0] ZERO_SIZE_SPAN = 32'h0001_0000;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] address;
    logic [31:0] symbol_size;
    logic [7:0]  symbol_info;
    logic [15:0] section_index;
    logic [31:0] name_offset;
  } req_t;

  typedef struct packed {
    logic               accepted;
    logic               found;
    logic [31:0]        offset_in_symbol;
    logic [31:0]        matched_name_offset;
    logic               name_valid;
    logic [TOTAL_W-1:0] entry_total;
  } res_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
    logic [31:0] name_index;
    logic        name_ok;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_TOP,
    PTR_ZERO,
    PTR_DEC,
    PTR_INC
  } ptr_op_t;

  typedef struct packed {
    logic    capture;
    ptr_op_t ptr_op;
    logic    rd_below;
    logic    wr_shift;
    logic    wr_new;
    logic    take_best;
    logic    clear_cnt;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       ins_ok;
    logic       ptr_zero;
    logic       ptr_end;
    logic       start_gt;
  } status_t;

endpackage

`default_nettype wire

[rtl/ssrl_ram.sv]
`default_nettype none

module ssrl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/ssrl_datapath.sv]
`default_nettype none

module ssrl_datapath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ssrl_pkg::req_t   req,
  input  wire logic [31:0]      string_table_size,
  input  wire ssrl_pkg::cmd_t   cmd,
  output ssrl_pkg::status_t     status,
  output ssrl_pkg::res_t        res
);

  ssrl_pkg::req_t                 req_q;
  ssrl_pkg::entry_t               best;
  ssrl_pkg::entry_t               rd_entry;
  ssrl_pkg::entry_t               new_entry;
  ssrl_pkg::entry_t               wr_entry;
  ssrl_pkg::res_t                 res_next;
  logic [ssrl_pkg::CNT_W-1:0]     count;
  logic [ssrl_pkg::CNT_W-1:0]     ptr;
  logic [ssrl_pkg::CNT_W-1:0]     ptr_m1;
  logic [ssrl_pkg::IDX_W-1:0]     raddr;
  logic [ssrl_pkg::ENTRY_W-1:0]   rdata;
  logic                           have;
  logic                           stored;
  logic [31:0]                    span;
  logic [31:0]                    limit;
  logic                           in_range;

  assign ptr_m1   = ptr - ssrl_pkg::CNT_W'(1);
  assign raddr    = cmd.rd_below ? ptr_m1[ssrl_pkg::IDX_W-1:0] : ptr[ssrl_pkg::IDX_W-1:0];
  assign rd_entry = ssrl_pkg::entry_t'(rdata);

  always_comb begin
    new_entry.start      = req_q.address;
    new_entry.length     = req_q.symbol_size;
    new_entry.name_index = req_q.name_offset;
    new_entry.name_ok    = (req_q.name_offset < string_table_size);
  end

  assign wr_entry = cmd.wr_new ? new_entry : rd_entry;

  ssrl_ram #(
    .WIDTH (ssrl_pkg::ENTRY_W),
    .DEPTH (ssrl_pkg::MAX_SYMBOLS)
  ) u_table (
    .clk   (clk),
    .we    (cmd.wr_shift | cmd.wr_new),
    .waddr (ptr[ssrl_pkg::IDX_W-1:0]),
    .wdata (wr_entry),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    status.req_type = req_q.req_type;
    status.ins_ok   = (req_q.symbol_info[3:0] == ssrl_pkg::FUNC_TYPE) &&
                      (req_q.section_index != 16'd0) &&
                      (req_q.address != 32'd0) &&
                      (count < ssrl_pkg::CNT_W'(ssrl_pkg::MAX_SYMBOLS));
    status.ptr_zero = (ptr == '0);
    status.ptr_end  = (ptr == count);
    status.start_gt = (rd_entry.start > req_q.address);
  end

  assign span     = (best.length != 32'd0) ? best.length : ssrl_pkg::ZERO_SIZE_SPAN;
  assign limit    = best.start + span;
  assign in_range = have && (req_q.address <= limit);

  always_comb begin
    res_next = '0;
    res_next.entry_total = ssrl_pkg::TOTAL_W'(count);
    if (req_q.req_type == ssrl_pkg::REQ_INSERT) begin
      res_next.accepted = stored;
    end
    if (req_q.req_type == ssrl_pkg::REQ_LOOKUP && in_range) begin
      res_next.found               = 1'b1;
      res_next.offset_in_symbol    = req_q.address - best.start;
      res_next.matched_name_offset = best.name_index;
      res_next.name_valid          = best.name_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      ptr    <= '0;
      have   <= 1'b0;
      stored <= 1'b0;
    end else begin
      if (cmd.clear_cnt) begin
        count <= '0;
      end else if (cmd.wr_new) begin
        count <= count + ssrl_pkg::CNT_W'(1);
      end
      case (cmd.ptr_op)
        ssrl_pkg::PTR_TOP:  ptr <= count;
        ssrl_pkg::PTR_ZERO: ptr <= '0;
        ssrl_pkg::PTR_DEC:  ptr <= ptr_m1;
        ssrl_pkg::PTR_INC:  ptr <= ptr + ssrl_pkg::CNT_W'(1);
        default:            ptr <= ptr;
      endcase
      if (cmd.capture) begin
        have   <= 1'b0;
        stored <= 1'b0;
      end else begin
        if (cmd.take_best) begin
          have <= 1'b1;
        end
        if (cmd.wr_new) begin
          stored <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
    if (cmd.take_best) begin
      best <= rd_entry;
    end
    if (cmd.load_out) begin
      res <= res_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ssrl_pkg::CNT_W'(ssrl_pkg::MAX_SYMBOLS))
    else $error("entry count beyond table depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_new |=> count == $past(count) + ssrl_pkg::CNT_W'(1))
    else $error("stored entry did not advance the count");

  a_ins_room: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_new |-> count < ssrl_pkg::CNT_W'(ssrl_pkg::MAX_SYMBOLS))
    else $error("entry stored into a full table");

endmodule

`default_nettype wire

[rtl/ssrl_ctrl.sv]
`default_nettype none

module ssrl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  output logic                   res_valid,
  input  wire logic              res_stall,
  input  wire ssrl_pkg::status_t status,
  output ssrl_pkg::cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INS_RD,
    S_INS_CMP,
    S_LK_RD,
    S_LK_CMP,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign req_stall = (state != S_IDLE);
  assign out_free  = !res_valid || !res_stall;

  always_comb begin
    cmd        = '0;
    cmd.ptr_op = ssrl_pkg::PTR_HOLD;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status.req_type)
          ssrl_pkg::REQ_INSERT: begin
            if (status.ins_ok) begin
              cmd.ptr_op = ssrl_pkg::PTR_TOP;
              state_next = S_INS_RD;
            end else begin
              state_next = S_FINISH;
            end
          end
          ssrl_pkg::REQ_LOOKUP: begin
            cmd.ptr_op = ssrl_pkg::PTR_ZERO;
            state_next = S_LK_RD;
          end
          ssrl_pkg::REQ_CLEAR: begin
            cmd.clear_cnt = 1'b1;
            state_next    = S_FINISH;
          end
          ssrl_pkg::REQ_NOP: begin
            state_next = S_FINISH;
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_INS_RD: begin
        if (status.ptr_zero) begin
          cmd.wr_new = 1'b1;
          state_next = S_FINISH;
        end else begin
          cmd.rd_below = 1'b1;
          state_next   = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (status.start_gt) begin
          cmd.wr_shift = 1'b1;
          cmd.ptr_op   = ssrl_pkg::PTR_DEC;
          state_next   = S_INS_RD;
        end else begin
          cmd.wr_new = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_LK_RD: begin
        if (status.ptr_end) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_LK_CMP;
        end
      end
      S_LK_CMP: begin
        if (!status.start_gt) begin
          cmd.take_best = 1'b1;
          cmd.ptr_op    = ssrl_pkg::PTR_INC;
          state_next    = S_LK_RD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_new_then_finish: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_new |=> state == S_FINISH)
    else $error("new entry written outside the last insert step");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(res_valid && res_stall))
    else $error("result overwritten while held");

  a_write_insert: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_new || cmd.wr_shift) |-> status.req_type == ssrl_pkg::REQ_INSERT)
    else $error("table written by a request that is not an insert");

endmodule

`default_nettype wire

[rtl/sorted_symbol_range_lookup.sv]
// Sorted function-symbol table with nearest-lower-address lookup.
// Requests arrive on req (req_valid/req_stall) and each one yields exactly
// one result on res (res_valid/res_stall). A request is taken when valid is
// high and stall is low. One request is worked on at a time: the block
// stalls its input from the cycle after acceptance until that request's
// result has been loaded into the output register.
// A clear, a no-operation or a rejected insert passes from acceptance
// through the decode and finish states to its result. An insert visits
// each stored entry with a start above the new address, and a lookup
// each entry at or below the query. Both walks are paced by the single
// symbol memory, whose read data is registered, so each visited entry costs
// a read step and a compare step. The user must write the string_table_size
// register (byte address 0) through the APB port only while the block is
// idle; the block itself does not enforce this. The register is sampled
// when an insert is stored.
// Reset empties the table and clears the register; no clearing pass runs.
// A held result stays on res while res_stall is high, and a new request may
// still be accepted and worked on behind it.
`default_nettype none

module sorted_symbol_range_lookup (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire ssrl_pkg::req_t req,
  output logic                res_valid,
  input  wire logic           res_stall,
  output ssrl_pkg::res_t      res,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [2:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam logic [2:0] ADDR_STRTAB_SIZE = 3'd0;

  logic [31:0]       string_table_size;
  logic              reg_hit;
  ssrl_pkg::cmd_t    cmd;
  ssrl_pkg::status_t status;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == ADDR_STRTAB_SIZE[2]);
  assign prdata  = reg_hit ? string_table_size : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      string_table_size <= 32'd0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      string_table_size <= pwdata;
    end
  end

  ssrl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ssrl_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .req               (req),
    .string_table_size (string_table_size),
    .cmd               (cmd),
    .status            (status),
    .res               (res)
  );

endmodule

`default_nettype wire

[tb/sv/ssrl_result_checker.sv]
`default_nettype none

module ssrl_result_checker
  import ssrl_pkg::*;
#(
  parameter logic [2:0] TAB_SIZE_ADDR = 3'd0
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  input  wire logic        req_stall,
  input  wire req_t        req,
  input  wire logic        res_valid,
  input  wire logic        res_stall,
  input  wire res_t        res,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic [31:0] prdata,
  input  wire logic        pready,
  output int               fail_count,
  output int               pending,
  output int               checked,
  output int               stored,
  output int               hits,
  output int               full_refusals,
  output int               peak_entries
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] sym_start   [MAX_SYMBOLS];
  logic [31:0] sym_len     [MAX_SYMBOLS];
  logic [31:0] sym_name    [MAX_SYMBOLS];
  logic        sym_name_ok [MAX_SYMBOLS];
  int          sym_count;
  logic [31:0] strtab_size;
  res_t        table_replies[$];

  function automatic res_t answer_request(input req_t r);
    res_t        reply;
    int          pos;
    int          k;
    int          best;
    logic [31:0] span;
    logic [31:0] last_byte;
    reply = '0;
    case (r.req_type)
      REQ_INSERT: begin
        if (r.symbol_info[3:0] == FUNC_TYPE && r.section_index != '0 && r.address != '0) begin
          if (sym_count >= MAX_SYMBOLS) begin
            full_refusals++;
          end else begin
            pos = 0;
            while (pos < sym_count && sym_start[pos] <= r.address) pos++;
            for (k = sym_count; k > pos; k--) begin
              sym_start[k]   = sym_start[k-1];
              sym_len[k]     = sym_len[k-1];
              sym_name[k]    = sym_name[k-1];
              sym_name_ok[k] = sym_name_ok[k-1];
            end
            sym_start[pos]   = r.address;
            sym_len[pos]     = r.symbol_size;
            sym_name[pos]    = r.name_offset;
            sym_name_ok[pos] = (r.name_offset < strtab_size);
            sym_count++;
            stored++;
            reply.accepted = 1'b1;
          end
        end
      end
      REQ_LOOKUP: begin
        best = -1;
        for (k = 0; k < sym_count && sym_start[k] <= r.address; k++) best = k;
        if (best >= 0) begin
          span = (sym_len[best] != '0) ? sym_len[best] : ZERO_SIZE_SPAN;
          last_byte = sym_start[best] + span;
          if (r.address <= last_byte) begin
            reply.found               = 1'b1;
            reply.offset_in_symbol    = r.address - sym_start[best];
            reply.matched_name_offset = sym_name[best];
            reply.name_valid          = sym_name_ok[best];
            hits++;
          end
        end
      end
      REQ_CLEAR: begin
        sym_count = 0;
      end
      default: begin
      end
    endcase
    reply.entry_total = TOTAL_W'(sym_count);
    if (sym_count > peak_entries) peak_entries = sym_count;
    return reply;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      sym_count = 0;
      strtab_size = '0;
      table_replies.delete();
    end else begin
      if (psel && penable && pready && paddr == TAB_SIZE_ADDR) begin
        if (pwrite) begin
          strtab_size = pwdata;
        end else begin
          check_field("string table size readback", strtab_size, prdata);
        end
      end
      if (res_valid && !res_stall) begin
        checked++;
        if (table_replies.size() == 0) begin
          $display("%0t: result %h arrived with no request outstanding", $time, res);
          fail_count++;
        end else begin
          want = table_replies.pop_front();
          check_field("accepted", 32'(want.accepted), 32'(res.accepted));
          check_field("found", 32'(want.found), 32'(res.found));
          check_field("offset_in_symbol", want.offset_in_symbol, res.offset_in_symbol);
          check_field("matched_name_offset", want.matched_name_offset,
                      res.matched_name_offset);
          check_field("name_valid", 32'(want.name_valid), 32'(res.name_valid));
          check_field("entry_total", 32'(want.entry_total), 32'(res.entry_total));
        end
      end
      if (req_valid && !req_stall) table_replies.push_back(answer_request(req));
    end
    pending = table_replies.size();
  end

endmodule

`default_nettype wire

[tb/sv/tb_sorted_symbol_range_lookup.sv]
`default_nettype none

module tb_sorted_symbol_range_lookup;
  timeunit 1ns;
  timeprecision 1ps;

  import ssrl_pkg::*;

  localparam logic [2:0]  TAB_SIZE_ADDR  = 3'd0;
  localparam int unsigned CYCLE_LIMIT    = 4_000_000;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          SETTLE_CYCLES  = 1100;
  localparam int          TABLE_SOFT_CAP = 40;
  localparam int          PHASE_ITEMS    = 4;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_t        req;
  logic        res_valid;
  logic        res_stall;
  res_t        res;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int checked;
  int stored;
  int hits;
  int full_refusals;
  int peak_entries;

  bit          hold_requested;
  bit          back_to_back;
  int          requests_sent;
  int          entries_since_clear;
  int unsigned cycle_count;
  logic [31:0] tab_size;
  logic [31:0] known_start[$];
  logic [31:0] known_span[$];

  sorted_symbol_range_lookup uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ssrl_result_checker #(.TAB_SIZE_ADDR(TAB_SIZE_ADDR)) result_check (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .fail_count(fail_count), .pending(pending), .checked(checked),
    .stored(stored), .hits(hits), .full_refusals(full_refusals),
    .peak_entries(peak_entries)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count, pending);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : result_side
    int free_len;
    int stall_len;
    res_stall = 1'b0;
    forever begin
      free_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 6);
      repeat (free_len) @(negedge clk);
      if (hold_requested) begin
        hold_requested = 1'b0;
        stall_len = HOLD_CYCLES;
      end else if ($urandom_range(0, 19) == 0) begin
        stall_len = $urandom_range(20, 80);
      end else begin
        stall_len = $urandom_range(1, 4);
      end
      res_stall <= 1'b1;
      repeat (stall_len) @(negedge clk);
      res_stall <= 1'b0;
    end
  end

  function automatic req_t make_req(input logic [1:0] code, input logic [31:0] addr,
                                    input logic [31:0] size, input logic [7:0] info,
                                    input logic [15:0] sect, input logic [31:0] name);
    req_t r;
    r.req_type      = code;
    r.address       = addr;
    r.symbol_size   = size;
    r.symbol_info   = info;
    r.section_index = sect;
    r.name_offset   = name;
    return r;
  endfunction

  function automatic req_t scrambled(input logic [1:0] code);
    return make_req(code, $urandom, $urandom, 8'($urandom), 16'($urandom), $urandom);
  endfunction

  function automatic logic [31:0] pick_size();
    int k;
    k = $urandom_range(0, 99);
    if (k < 30) return '0;
    if (k < 70) return $urandom_range(1, 'h800);
    if (k < 85) return $urandom_range('h801, 'h40000);
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_name();
    int k;
    k = $urandom_range(0, 99);
    if (k < 35) return $urandom;
    if (k < 70) return $urandom_range(0, 'h3ff);
    return tab_size + $urandom_range(0, 4) - 32'd2;
  endfunction

  task automatic offer(input req_t r);
    int gap;
    int k;
    k = $urandom_range(0, 99);
    if (back_to_back || k < 55) gap = 0;
    else if (k < 88) gap = $urandom_range(1, 3);
    else if (k < 97) gap = $urandom_range(4, 15);
    else gap = $urandom_range(30, 90);
    if (gap > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    requests_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    wait (pending == 0);
  endtask

  task automatic apb_access(input bit is_write, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= TAB_SIZE_ADDR;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_table_size(input logic [31:0] value);
    drain();
    apb_access(1'b1, value);
    apb_access(1'b0, '0);
    tab_size = value;
  endtask

  task automatic offer_clear();
    offer(scrambled(REQ_CLEAR));
    known_start.delete();
    known_span.delete();
    entries_since_clear = 0;
  endtask

  task automatic probe_at(input logic [31:0] addr);
    req_t r;
    r = scrambled(REQ_LOOKUP);
    r.address = addr;
    offer(r);
  endtask

  task automatic offer_symbol(input logic [31:0] base, input bit well_formed);
    req_t r;
    r = make_req(REQ_INSERT, base + $urandom_range(0, 'h3ffff), pick_size(),
                 {4'($urandom_range(0, 15)), FUNC_TYPE}, 16'($urandom_range(1, 'hffff)),
                 pick_name());
    if (!well_formed) begin
      case ($urandom_range(0, 2))
        0: r.symbol_info[3:0] ^= 4'($urandom_range(1, 15));
        1: r.section_index = '0;
        default: r.address = '0;
      endcase
    end
    if (r.symbol_info[3:0] == FUNC_TYPE && r.section_index != '0 && r.address != '0) begin
      known_start.push_back(r.address);
      known_span.push_back(r.symbol_size != '0 ? r.symbol_size : ZERO_SIZE_SPAN);
      entries_since_clear++;
    end
    offer(r);
  endtask

  task automatic offer_probe();
    int          k;
    int          idx;
    logic [31:0] s;
    logic [31:0] span;
    logic [31:0] addr;
    k = $urandom_range(0, 99);
    if (known_start.size() == 0 || k < 10) begin
      addr = $urandom;
    end else begin
      idx = $urandom_range(0, known_start.size() - 1);
      s = known_start[idx];
      span = known_span[idx];
      k = $urandom_range(0, 99);
      if (k < 20) addr = s;
      else if (k < 45) addr = s + $urandom_range(0, span);
      else if (k < 60) addr = s + span;
      else if (k < 72) addr = s + span + 32'd1;
      else if (k < 82) addr = s - 32'd1;
      else addr = s + $urandom_range(0, 'h3ffff);
    end
    probe_at(addr);
  endtask

  task automatic run_session(input int n);
    logic [31:0] base;
    int          k;
    int          i;
    k = $urandom_range(0, 99);
    if (k < 70) base = $urandom;
    else if (k < 85) base = 32'hFFFF_FFFF - $urandom_range(0, 'h4ffff);
    else base = $urandom_range(0, 'h1ffff);
    back_to_back = ($urandom_range(0, 5) == 0);
    for (i = 0; i < n; i++) begin
      if (entries_since_clear >= TABLE_SOFT_CAP) offer_clear();
      k = $urandom_range(0, 99);
      if (k < 42) offer_symbol(base, 1'b1);
      else if (k < 50) offer_symbol(base, 1'b0);
      else if (k < 90) offer_probe();
      else if (k < 94) offer(scrambled(REQ_NOP));
      else offer_clear();
    end
    back_to_back = 1'b0;
  endtask

  initial begin : stimulus
    logic [31:0] directed_probes[9];
    logic [31:0] phase_sizes[3];
    logic [31:0] base;
    logic [31:0] top_addr;
    req_t        r;
    int          p;
    int          i;
    int          phase_end;

    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tab_size = '0;
    directed_probes = '{32'h0000_0000, 32'h0000_0002, 32'h0000_1000, 32'h0001_1000,
                        32'h0001_1001, 32'h0000_2010, 32'hFFFF_FFF0, 32'hFFFF_FFFF,
                        32'h0000_0FFF};
    phase_sizes = '{32'h0000_0400, 32'h0000_0000, 32'hFFFF_FFFF};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_table_size(32'h0000_0100);
    offer(scrambled(REQ_LOOKUP));
    offer(scrambled(REQ_CLEAR));
    offer(scrambled(REQ_NOP));
    offer(make_req(REQ_INSERT, 32'h0000_1000, 32'h20, 8'hF1, 16'h0001, 32'h10));
    offer(make_req(REQ_INSERT, 32'h0000_1000, 32'h20, 8'h12, 16'h0000, 32'h10));
    offer(make_req(REQ_INSERT, 32'h0000_0000, 32'h20, 8'h12, 16'h0001, 32'h10));
    offer(make_req(REQ_INSERT, 32'h0000_1000, 32'h20, 8'h02, 16'h0001, 32'h10));
    offer(make_req(REQ_INSERT, 32'h0000_1000, 32'h0, 8'hF2, 16'hFFFF, 32'h100));
    offer(make_req(REQ_INSERT, 32'hFFFF_FFF0, 32'h40, 8'h22, 16'h8000, 32'hFFFF_FFFF));
    offer(make_req(REQ_INSERT, 32'h0000_0001, 32'hFFFF_FFFF, 8'h12, 16'h0001, 32'h0));
    offer(make_req(REQ_INSERT, 32'hFFFF_FFFF, 32'h1, 8'hA2, 16'h7FFF, 32'hFF));
    offer(make_req(REQ_INSERT, 32'h0000_2000, 32'h10, 8'h52, 16'h0002, 32'hFF));
    foreach (directed_probes[i]) probe_at(directed_probes[i]);
    offer_clear();
    probe_at(32'h0000_1000);

    for (p = 0; p < 4; p++) begin
      write_table_size(p < 3 ? phase_sizes[p] : $urandom);
      if (p == 1) begin
        // The result side holds off while requests keep coming, so the block backs up.
        hold_requested = 1'b1;
        back_to_back = 1'b1;
        base = $urandom;
        for (i = 0; i < 16 || hold_requested; i++) begin
          if (i % 2 == 0) offer_symbol(base, 1'b1);
          else offer_probe();
        end
        back_to_back = 1'b0;
      end
      phase_end = requests_sent + PHASE_ITEMS;
      while (requests_sent < phase_end) run_session($urandom_range(4, 8));
    end

    write_table_size($urandom_range(1, 'hffff));
    offer_clear();
    base = $urandom_range(2, 'h7fff_ffff);
    top_addr = base;
    for (i = 0; i < MAX_SYMBOLS; i++) begin
      r = make_req(REQ_INSERT, top_addr, $urandom_range(0, 'h1ff),
                   {4'($urandom_range(0, 15)), FUNC_TYPE}, 16'($urandom_range(1, 'hffff)),
                   pick_name());
      if (i % 64 == 63) begin
        r.address = base + $urandom_range(0, top_addr - base);
      end else begin
        top_addr += ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 'h200);
        r.address = top_addr;
      end
      offer(r);
    end
    for (i = 0; i < 6; i++) begin
      offer(make_req(REQ_INSERT, base + $urandom_range(0, top_addr - base),
                     $urandom_range(0, 'h1ff), 8'h12, 16'h0001, pick_name()));
    end
    probe_at(base - 32'd1);
    probe_at(top_addr);
    for (i = 0; i < 8; i++) probe_at(base + $urandom_range(0, top_addr - base + 'h400));
    offer_clear();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d requests and checked %0d results: %0d symbols stored, %0d lookups hit.",
             requests_sent, checked, stored, hits);
    $display("Table peaked at %0d entries, refused %0d inserts when full; %0d failures.",
             peak_entries, full_refusals, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/ssrl_pkg.sv
rtl/ssrl_ram.sv
rtl/ssrl_datapath.sv
rtl/ssrl_ctrl.sv
rtl/sorted_symbol_range_lookup.sv
tb/sv/ssrl_result_checker.sv
tb/sv/tb_sorted_symbol_range_lookup.sv
